@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ src/fbpg_pkg.sv @@
// ----------------------------------------------------------------------------
// fbpg_pkg
// Shared types, constants and helpers of the feather border pixel generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fbpg_pkg;

  localparam int MAX_DIM   = 2048;
  localparam int FQ_DEPTH  = 4;
  localparam int PTR_W     = $clog2(FQ_DEPTH);
  localparam int CNT_W     = $clog2(FQ_DEPTH + 1);
  localparam int SQ_STEPS  = 12;
  localparam int DIV_STEPS = 8;
  localparam int RAD_W     = 24;
  localparam int REM_W     = 20;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_CORNER,
    KIND_EDGE
  } kind_t;

  typedef enum logic [1:0] {
    REG_BORDER,
    REG_WIDTH,
    REG_HEIGHT,
    REG_COLOR
  } reg_idx_t;

  // Classified request handed from front to back.
  typedef struct packed {
    kind_t        kind;
    logic [31:0]  word;
    logic [11:0]  s11;
    logic [7:0]   s;
    logic [7:0]   d;
    logic [11:0]  a;
    logic [11:0]  b;
  } fe_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             afull;
  } q_stat_t;

  // floor(v/10) for any 12-bit v, by reciprocal multiply.
  function automatic logic [8:0] div10(input logic [11:0] v);
    logic [23:0] p;
    p = {12'b0, v} * 24'd3277;
    return p[23:15];
  endfunction

endpackage

@@ src/fbpg_front.sv @@
// ----------------------------------------------------------------------------
// fbpg_front
// Registers a request and classifies it into pass, corner or edge work.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbpg_front import fbpg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [11:0] pos_x,
  input  logic [11:0] pos_y,
  input  logic [31:0] src_pixel,
  input  logic [7:0]  border_size,
  input  logic [11:0] image_width,
  input  logic [11:0] image_height,
  input  logic [23:0] border_rgb,
  output logic        push,
  output fe_t         entry
);

  localparam logic [11:0] DIM_MAX = 12'(MAX_DIM);

  logic        vld;
  logic [11:0] x, y, w, h;
  logic [31:0] src;
  logic [7:0]  s;
  logic [23:0] base;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= start && !busy;
    end
    if (start && !busy) begin
      x    <= pos_x;
      y    <= pos_y;
      src  <= src_pixel;
      s    <= border_size;
      w    <= (image_width > DIM_MAX) ? DIM_MAX : image_width;
      h    <= (image_height > DIM_MAX) ? DIM_MAX : image_height;
      base <= border_rgb;
    end
  end

  logic [12:0] xe, ye, se, cw, ch, mx, my, ri, dx, dy, s11e;
  logic        off, inx, iny, okx, oky, pxo, mxo, pyo, myo;
  logic [11:0] s11;
  logic [12:0] ed;

  always_comb begin
    xe   = {1'b0, x};
    ye   = {1'b0, y};
    se   = {5'b0, s};
    cw   = {1'b0, w} + (se << 1);
    ch   = {1'b0, h} + (se << 1);
    s11  = 12'({4'b0, s} * 12'd11);
    s11e = {1'b0, s11};
    ri   = {4'b0, div10(s11)};
    off  = (xe >= cw) || (ye >= ch);
    inx  = (xe >= se) && (xe < se + {1'b0, w});
    iny  = (ye >= se) && (ye < se + {1'b0, h});
    mx   = cw - 13'd1 - xe;
    my   = ch - 13'd1 - ye;
    pxo  = xe < ri;
    mxo  = mx < ri;
    pyo  = ye < ri;
    myo  = my < ri;
    okx  = pxo || mxo;
    oky  = pyo || myo;
    dx   = (mxo && (!pxo || mx > xe)) ? mx : xe;
    dy   = (myo && (!pyo || my > ye)) ? my : ye;
    if (s != 8'd0 && inx) begin
      ed = (ye < se) ? ye : my;
    end else begin
      ed = (xe < se) ? xe : mx;
    end

    entry.s11 = s11;
    entry.s   = s;
    entry.d   = ed[7:0];
    entry.a   = 12'(s11e - 13'(dx * 13'd10));
    entry.b   = 12'(s11e - 13'(dy * 13'd10));
    if (off) begin
      entry.kind = KIND_PASS;
      entry.word = 32'd0;
    end else if (inx && iny) begin
      entry.kind = KIND_PASS;
      entry.word = src;
    end else if (okx && oky) begin
      entry.kind = KIND_CORNER;
      entry.word = {8'd0, base};
    end else if (s != 8'd0 && (inx || iny)) begin
      entry.kind = KIND_EDGE;
      entry.word = {8'd0, base};
    end else begin
      entry.kind = KIND_PASS;
      entry.word = 32'd0;
    end
    push = vld;
  end

endmodule

@@ src/fbpg_fifo.sv @@
// ----------------------------------------------------------------------------
// fbpg_fifo
// Short request queue between front and back; drains whenever not empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbpg_fifo import fbpg_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  fe_t     wr_data,
  output fe_t     rd_data,
  output logic    rd_vld,
  output q_stat_t stat
);

  fe_t              mem [FQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;

  assign do_push = push && (count != CNT_W'(FQ_DEPTH));
  assign rd_vld  = count != '0;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (rd_vld)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + CNT_W'(do_push) - CNT_W'(rd_vld);
    end
    if (do_push) mem[wr_ptr] <= wr_data;
  end

  assign stat.count = count;
  assign stat.afull = count >= CNT_W'(FQ_DEPTH - 1);

endmodule

@@ src/fbpg_back.sv @@
// ----------------------------------------------------------------------------
// fbpg_back
// Pipelined alpha datapath: squares, root, scaling and quotient stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbpg_back import fbpg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_vld,
  input  fe_t         in_req,
  output logic        done,
  output logic [31:0] out_pixel
);

  localparam int SQ0   = 2;
  localparam int SCL0  = SQ0 + SQ_STEPS;
  localparam int DIV0  = SCL0 + 2;
  localparam int N_STG = DIV0 + DIV_STEPS;

  typedef struct packed {
    logic             border;
    logic             corner;
    logic [31:0]      word;
    logic [11:0]      s11;
    logic [7:0]       s;
    logic [7:0]       d;
    logic [RAD_W-1:0] aa;
    logic [RAD_W-1:0] bb;
    logic [RAD_W-1:0] v;
    logic [RAD_W-1:0] res;
    logic [8:0]       r;
    logic [REM_W-1:0] rem;
    logic [11:0]      dv;
    logic [7:0]       q;
  } bk_t;

  function automatic bk_t stage_fn(input int k, input bk_t p);
    bk_t              o;
    logic [RAD_W:0]   t;
    logic [RAD_W-1:0] bitv;
    logic [REM_W-1:0] dsh;
    logic [12:0]      tr;
    int               sh;
    o = p;
    if (k == 1) begin
      o.v   = p.aa + p.bb;
      o.res = '0;
    end else if (k < SCL0) begin
      bitv = RAD_W'(1) << (RAD_W - 2 - 2 * (k - SQ0));
      t    = {1'b0, p.res} + {1'b0, bitv};
      if ({1'b0, p.v} >= t) begin
        o.v   = p.v - t[RAD_W-1:0];
        o.res = (p.res >> 1) + bitv;
      end else begin
        o.res = p.res >> 1;
      end
    end else if (k == SCL0) begin
      o.r = div10(p.res[11:0]);
    end else if (k == SCL0 + 1) begin
      tr  = 13'({4'b0, p.r} * 13'd10);
      o.q = '0;
      if (p.corner) begin
        o.dv  = p.s11;
        o.rem = (tr > {1'b0, p.s11}) ? '0 :
                REM_W'(({1'b0, p.s11} - tr) * 20'd200);
      end else begin
        o.dv  = {4'b0, p.s};
        o.rem = REM_W'({12'b0, p.d} * 20'd200);
      end
    end else begin
      sh  = DIV0 + DIV_STEPS - 1 - k;
      dsh = {8'b0, p.dv} << sh;
      if (p.rem >= dsh) begin
        o.rem        = p.rem - dsh;
        o.q[3'(sh)]  = 1'b1;
      end
    end
    return o;
  endfunction

  bk_t  stg [N_STG];
  bk_t  nxt [N_STG];
  logic vld [N_STG];

  always_comb begin
    nxt[0]        = '0;
    nxt[0].border = in_req.kind != KIND_PASS;
    nxt[0].corner = in_req.kind == KIND_CORNER;
    nxt[0].word   = in_req.word;
    nxt[0].s11    = in_req.s11;
    nxt[0].s      = in_req.s;
    nxt[0].d      = in_req.d;
    if (in_req.kind == KIND_CORNER) begin
      nxt[0].aa = {12'b0, in_req.a} * {12'b0, in_req.a};
      nxt[0].bb = {12'b0, in_req.b} * {12'b0, in_req.b};
    end
    for (int k = 1; k < N_STG; k++) begin
      nxt[k] = stage_fn(k, stg[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < N_STG; k++) vld[k] <= 1'b0;
    end else begin
      vld[0] <= in_vld;
      for (int k = 1; k < N_STG; k++) vld[k] <= vld[k-1];
    end
    for (int k = 0; k < N_STG; k++) stg[k] <= nxt[k];
  end

  assign done      = vld[N_STG-1];
  assign out_pixel = stg[N_STG-1].border ? {stg[N_STG-1].q, stg[N_STG-1].word[23:0]}
                                         : stg[N_STG-1].word;

endmodule

@@ src/feather_border_pixel_generator.sv @@
// ----------------------------------------------------------------------------
// feather_border_pixel_generator
// Image framed by a feathered border: one ARGB pixel per canvas request.
// ----------------------------------------------------------------------------
// A request (pos_x, pos_y, src_pixel) is taken on any clock edge with start
// high and busy low, one per cycle with no gaps while busy stays low. Its
// out_pixel appears with done high for exactly one cycle, after the front
// register, queue and back end, in request order. The receiver cannot stall:
// results are never held. The back end has two square/sum stages, a 12-stage
// one-bit-per-stage square root, two scaling stages and an 8-stage
// restoring quotient. busy only rises if the front-to-back queue nears full,
// which the always-draining back end never lets happen in practice.
// Config registers (border_size, image_width, image_height, border_rgb) are
// written through cfg_we/cfg_index/cfg_data and must only change while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module feather_border_pixel_generator import fbpg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] pos_x,
  input  logic [11:0] pos_y,
  input  logic [31:0] src_pixel,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output logic        done,
  output logic [31:0] out_pixel
);

  // Config registers, reset to a 640x480 image with a 16-pixel border.
  logic [7:0]  border_size;
  logic [11:0] image_width;
  logic [11:0] image_height;
  logic [23:0] border_rgb;

  always_ff @(posedge clk) begin
    if (rst) begin
      border_size  <= 8'd16;
      image_width  <= 12'd640;
      image_height <= 12'd480;
      border_rgb   <= 24'd0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_BORDER: border_size  <= cfg_data[7:0];
        REG_WIDTH:  image_width  <= cfg_data[11:0];
        REG_HEIGHT: image_height <= cfg_data[11:0];
        REG_COLOR:  border_rgb   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: register and classify the request.
  logic    push;
  fe_t     entry;
  fe_t     head;
  logic    head_vld;
  q_stat_t q_stat;

  assign busy = q_stat.afull;

  fbpg_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .src_pixel    (src_pixel),
    .border_size  (border_size),
    .image_width  (image_width),
    .image_height (image_height),
    .border_rgb   (border_rgb),
    .push         (push),
    .entry        (entry)
  );

  // Queue decouples classification from the alpha datapath.
  fbpg_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (entry),
    .rd_data (head),
    .rd_vld  (head_vld),
    .stat    (q_stat)
  );

  // Back: fixed-latency alpha pipeline, one request per cycle.
  fbpg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (head_vld),
    .in_req    (head),
    .done      (done),
    .out_pixel (out_pixel)
  );

  // Back end pops whenever the queue is non-empty: it never holds more than one.
  `ASSERT_NEVER(a_q_shallow, q_stat.count > CNT_W'(1), "queue deeper than one")
  `ASSERT_NEVER(a_no_busy, busy, "busy raised with a draining back end")
  `ASSERT_CLK(a_front_push, start && !busy |=> push, "accepted request not pushed")

endmodule
